@@ design/irpwt_pkg.sv @@
// Shared types, constants and register codes for the IR pulse-width transmitter.
// Depends on nothing; irpwt_cfg, irpwt_core, the top level and the checker import it.
package irpwt_pkg;

  localparam int COMMAND_BITS_DEFAULT = 16;

  localparam int CMD_W    = 16;
  localparam int TOP_W    = 4;
  localparam int MARK_W   = 10;
  localparam int GAP_W    = 16;
  localparam int REP_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 8;

  localparam logic [MARK_W-1:0] ONE_MARK_RESET   = 10'd94;
  localparam logic [MARK_W-1:0] ZERO_MARK_RESET  = 10'd30;
  localparam logic [MARK_W-1:0] BIT_PERIOD_RESET = 10'd128;
  localparam logic [GAP_W-1:0]  GAP_RESET        = 16'd540;
  localparam logic [REP_W-1:0]  REPEAT_RESET     = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_MARK   = 3'd0,
    CFG_ZERO_MARK  = 3'd1,
    CFG_BIT_PERIOD = 3'd2,
    CFG_GAP        = 3'd3,
    CFG_REPEAT     = 3'd4
  } cfg_index_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEND = 3'b010,
    PH_GAP  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [MARK_W-1:0] one_mark_ticks;
    logic [MARK_W-1:0] zero_mark_ticks;
    logic [MARK_W-1:0] bit_period_ticks;
    logic [GAP_W-1:0]  gap_ticks;
    logic [REP_W-1:0]  repeat_total;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [TOP_W-1:0] top_bit_index;
    logic [CMD_W-1:0] command_word;
  } item_t;

  typedef struct packed {
    logic frame_done;
    logic busy_res;
    logic ir_drive;
  } result_t;

endpackage

@@ design/irpwt_cfg.sv @@
// Configuration register file of the IR pulse-width transmitter.
// Depends on irpwt_pkg for the register codes and reset values.
module irpwt_cfg import irpwt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_mark_ticks   <= ONE_MARK_RESET;
      cfg.zero_mark_ticks  <= ZERO_MARK_RESET;
      cfg.bit_period_ticks <= BIT_PERIOD_RESET;
      cfg.gap_ticks        <= GAP_RESET;
      cfg.repeat_total     <= REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ONE_MARK:   cfg.one_mark_ticks   <= cfg_data[MARK_W-1:0];
        CFG_ZERO_MARK:  cfg.zero_mark_ticks  <= cfg_data[MARK_W-1:0];
        CFG_BIT_PERIOD: cfg.bit_period_ticks <= cfg_data[MARK_W-1:0];
        CFG_GAP:        cfg.gap_ticks        <= cfg_data[GAP_W-1:0];
        CFG_REPEAT:     cfg.repeat_total     <= cfg_data[REP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/irpwt_pipe_reg.sv @@
// One-entry pipeline register with valid/ready flow control.
// Depends on nothing; used for the input and the result stage.
module irpwt_pipe_reg #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  // The stage takes new data when empty or when its content leaves now.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

@@ design/irpwt_core.sv @@
// Frame sequencer of the IR pulse-width transmitter: state registers and the
// per-item next-state and result logic. Depends on irpwt_pkg.
module irpwt_core import irpwt_pkg::*; #(
  parameter int COMMAND_BITS = COMMAND_BITS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  // Command bits at or above COMMAND_BITS are held as zero.
  localparam logic [CMD_W-1:0] CMD_MASK = (COMMAND_BITS >= CMD_W) ? {CMD_W{1'b1}} :
      CMD_W'((17'd1 << COMMAND_BITS) - 17'd1);

  phase_t           phase, phase_next;
  logic [GAP_W-1:0] tick_count, tick_count_next;
  logic [TOP_W-1:0] bit_position, bit_position_next;
  logic [REP_W-1:0] repeats_left, repeats_left_next;
  logic [CMD_W-1:0] held_command, held_command_next;
  logic [TOP_W-1:0] held_top_index, held_top_index_next;
  logic             carrier_phase, carrier_phase_next;

  logic              cur_bit;
  logic [MARK_W-1:0] mark;
  logic [MARK_W-1:0] bit_len;
  logic [GAP_W:0]    tick_inc;
  logic              copy_end;
  logic [REP_W-1:0]  repeats_dec;
  logic              drive;
  logic              done;

  assign cur_bit  = held_command[bit_position];
  assign mark     = cur_bit ? cfg.one_mark_ticks : cfg.zero_mark_ticks;
  assign tick_inc = {1'b0, tick_count} + 17'd1;
  assign repeats_dec = repeats_left - REP_W'(1);

  always_comb begin
    if (mark > cfg.bit_period_ticks) begin
      bit_len = mark;
    end else if (cfg.bit_period_ticks == '0) begin
      bit_len = MARK_W'(1);
    end else begin
      bit_len = cfg.bit_period_ticks;
    end
  end

  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    bit_position_next   = bit_position;
    repeats_left_next   = repeats_left;
    held_command_next   = held_command;
    held_top_index_next = held_top_index;
    carrier_phase_next  = carrier_phase;
    copy_end            = 1'b0;
    drive               = 1'b0;
    done                = 1'b0;

    if (item.op == OP_START) begin
      if (phase == PH_IDLE) begin
        held_command_next   = item.command_word & CMD_MASK;
        held_top_index_next = item.top_bit_index;
        bit_position_next   = item.top_bit_index;
        repeats_left_next   = (cfg.repeat_total == '0) ? REP_W'(1) : cfg.repeat_total;
        tick_count_next     = '0;
        carrier_phase_next  = 1'b1;
        phase_next          = PH_SEND;
      end
    end else begin
      case (phase)
        PH_SEND: begin
          drive              = ({6'd0, mark} > tick_count) && carrier_phase;
          carrier_phase_next = !carrier_phase;
          if (tick_inc >= {7'd0, bit_len}) begin
            tick_count_next = '0;
            if (bit_position == '0) begin
              phase_next = PH_GAP;
              copy_end   = (cfg.gap_ticks == '0);
            end else begin
              bit_position_next = bit_position - TOP_W'(1);
            end
          end else begin
            tick_count_next = tick_inc[GAP_W-1:0];
          end
        end
        PH_GAP: begin
          carrier_phase_next = !carrier_phase;
          if (tick_inc >= {1'b0, cfg.gap_ticks}) begin
            copy_end = 1'b1;
          end else begin
            tick_count_next = tick_inc[GAP_W-1:0];
          end
        end
        default: ;
      endcase

      if (copy_end) begin
        repeats_left_next = repeats_dec;
        tick_count_next   = '0;
        if (repeats_dec == '0) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end else begin
          phase_next        = PH_SEND;
          bit_position_next = held_top_index;
        end
      end
    end
  end

  assign result.ir_drive   = drive;
  assign result.busy_res   = (phase_next != PH_IDLE);
  assign result.frame_done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      bit_position   <= '0;
      repeats_left   <= '0;
      held_command   <= '0;
      held_top_index <= '0;
      carrier_phase  <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      bit_position   <= bit_position_next;
      repeats_left   <= repeats_left_next;
      held_command   <= held_command_next;
      held_top_index <= held_top_index_next;
      carrier_phase  <= carrier_phase_next;
    end
  end

endmodule

@@ design/ir_pulse_width_transmitter.sv @@
// IR pulse-width transmitter top level. Each item passes through the input register, then the
// sequencer logic into the result register. Throughput: one item per cycle while the result
// stream is not stalled; irpwt_core updates its state once per item transfer.
// Reset (rst, synchronous, active high) empties both stages, returns the sequencer to
// idle and loads the register reset values. Depends on irpwt_pkg, irpwt_cfg, irpwt_pipe_reg and irpwt_core.
module ir_pulse_width_transmitter import irpwt_pkg::*; #(
  parameter int COMMAND_BITS = COMMAND_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream. tdata: command_word [15:0], top_bit_index [19:16], zero fill [23:20].
  // tuser: op (0 = one half carrier tick, 1 = start a command).
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]            s_axis_tuser,
  // Result stream. tdata: ir_drive [0], busy_res [1], zero fill [7:2].
  // tlast: frame_done, set on the tick that ends a command's last gap (last bit if gap_ticks is 0).
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tlast,
  // Configuration write port; indexes follow cfg_index_t.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   held_item;
  result_t result;
  result_t out_result;
  logic    held_valid;
  logic    res_ready;
  logic    fire;

  irpwt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the input transfer into the item fields.
  assign in_item.op            = op_t'(s_axis_tuser[0]);
  assign in_item.command_word  = s_axis_tdata[CMD_W-1:0];
  assign in_item.top_bit_index = s_axis_tdata[CMD_W+TOP_W-1:CMD_W];

  // Input register: holds one accepted item until the sequencer can process it.
  irpwt_pipe_reg #(.W($bits(item_t))) u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_item),
    .out_valid (held_valid),
    .out_ready (res_ready),
    .out_data  (held_item)
  );

  // The sequencer advances exactly when its item moves into the result register,
  // so a stalled output never advances the frame timing.
  assign fire = held_valid && res_ready;

  irpwt_core #(.COMMAND_BITS(COMMAND_BITS)) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held_item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register: lets the next item be taken while a result waits downstream.
  irpwt_pipe_reg #(.W($bits(result_t))) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (held_valid),
    .in_ready  (res_ready),
    .in_data   (result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_result)
  );

  assign m_axis_tdata = {6'd0, out_result.busy_res, out_result.ir_drive};
  assign m_axis_tlast = out_result.frame_done;

endmodule

@@ design/irpwt_checker.sv @@
// Port-level checker for the IR pulse-width transmitter, bound to the top level.
// Depends on irpwt_pkg for port widths.
module irpwt_checker import irpwt_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [M_TDATA_W-1:0]  m_axis_tdata,
  input logic                  m_axis_tlast
);

  // A stalled result transfer keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The transfer that ends a command also reports the transmitter as no longer busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[1])
    else $error("frame_done while still busy");

  // The fill bits above the result fields are always zero.
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:2] == '0)
    else $error("nonzero fill bits in result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind ir_pulse_width_transmitter irpwt_checker u_irpwt_checker (.*);
